// ----- design/mct_pkg.sv -----
package mct_pkg;

   // channel count and field widths
   localparam int NUM_CHANNELS = 4;
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CMD_W = 2;
   localparam int CH_W = 2;
   localparam int TIME_W = 32;
   localparam int OFFS_W = 16;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_MIN_OFFSET = '0;
   localparam logic [OFFS_W-1:0] MIN_OFFSET_RESET = 16'd1000;

   // item commands
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ARM_REL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ARM_ABS = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DISARM  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic finish;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic resched;
      logic scan_last;
   } stat_type;

endpackage

// ----- design/mct_regs.sv -----
module mct_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mct_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mct_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mct_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output logic [mct_pkg::OFFS_W-1:0]          min_offset
);

   logic [mct_pkg::OFFS_W-1:0] min_offset_ff;
   logic [mct_pkg::OFFS_W-1:0] min_offset_in;
   logic                       sel_min_offset;

   // word decode, byte offset bits ignored
   assign sel_min_offset = (paddr[mct_pkg::CSR_ADDR_W-1:2] == mct_pkg::REG_MIN_OFFSET);

   // register write
   always_comb begin
      min_offset_in = min_offset_ff;
      if (psel && penable && pwrite && sel_min_offset) begin
         min_offset_in = pwdata[mct_pkg::OFFS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_offset_ff <= mct_pkg::MIN_OFFSET_RESET;
      end else begin
         min_offset_ff <= min_offset_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (sel_min_offset) begin
         prdata = {{(mct_pkg::CSR_DATA_W - mct_pkg::OFFS_W){1'b0}}, min_offset_ff};
      end
   end

   assign pready     = 1'b1;
   assign min_offset = min_offset_ff;

endmodule

// ----- design/mct_ctrl.sv -----
module mct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mct_pkg::stat_type  stat,
   output mct_pkg::ctrl_type  ctrl,
   output logic               busy,
   output logic               rsp_valid
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINAL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // next state and result strobe
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.resched) begin
               state_in = ST_SCAN;
            end else begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath commands
   always_comb begin
      ctrl.load   = (state_ff == ST_IDLE) && start;
      ctrl.exec   = (state_ff == ST_EXEC);
      ctrl.scan   = (state_ff == ST_SCAN);
      ctrl.finish = (state_ff == ST_FINAL);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/mct_dpath.sv -----
module mct_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  mct_pkg::ctrl_type             ctrl,
   output mct_pkg::stat_type             stat,
   input  logic [mct_pkg::CMD_W-1:0]     req_command,
   input  logic [mct_pkg::CH_W-1:0]      req_channel,
   input  logic [mct_pkg::TIME_W-1:0]    req_value,
   input  logic [mct_pkg::OFFS_W-1:0]    min_offset,
   output logic                          rsp_fired,
   output logic [mct_pkg::CH_W-1:0]      rsp_fired_channel,
   output logic [mct_pkg::TIME_W-1:0]    rsp_current_time,
   output logic                          rsp_pending
);

   localparam int N = mct_pkg::NUM_CHANNELS;
   localparam int IW = mct_pkg::IDX_W;
   localparam int TW = mct_pkg::TIME_W;

   // captured item
   logic [mct_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [mct_pkg::CH_W-1:0]  ch_ff, ch_in;
   logic [TW-1:0]             val_ff, val_in;

   // timer state
   logic [TW-1:0]             time_ff, time_in;
   logic [TW-1:0]             deadline_ff [N];
   logic [N-1:0]              armed_ff, armed_in;
   logic [IW-1:0]             next_ff, next_in;
   logic [TW-1:0]             alarm_time_ff, alarm_time_in;
   logic                      alarm_valid_ff, alarm_valid_in;
   logic                      fired_ff, fired_in;
   logic [mct_pkg::CH_W-1:0]  fch_ff, fch_in;

   // scan state
   logic [IW-1:0]             idx_ff, idx_in;
   logic                      found_ff, found_in;
   logic [IW-1:0]             best_ff, best_in;
   logic [TW-1:0]             best_dl_ff, best_dl_in;

   // helpers
   logic                      is_tick;
   logic                      in_range;
   logic [IW-1:0]             ch_idx;
   logic [TW-1:0]             time_inc;
   logic                      hit;
   logic                      dl_write;
   logic [TW-1:0]             dl_value;
   logic [TW-1:0]             scan_dl;
   logic [TW-1:0]             ahead;
   logic                      due;

   assign is_tick  = (cmd_ff == mct_pkg::CMD_TICK);
   assign in_range = ({{(32 - mct_pkg::CH_W){1'b0}}, ch_ff} < 32'(N));
   assign ch_idx   = ch_ff[IW-1:0];
   assign time_inc = time_ff + 1'b1;
   assign hit      = is_tick && alarm_valid_ff && (time_inc == alarm_time_ff);
   assign scan_dl  = deadline_ff[idx_ff];
   assign ahead    = best_dl_ff - time_ff;
   assign due      = (best_dl_ff < time_ff) || (ahead == '0)
                   || (ahead < {{(TW - mct_pkg::OFFS_W){1'b0}}, min_offset});

   // deadline write on arm
   assign dl_write = ctrl.exec && !is_tick && in_range && (cmd_ff != mct_pkg::CMD_DISARM);
   assign dl_value = (cmd_ff == mct_pkg::CMD_ARM_REL) ? (time_ff + val_ff) : val_ff;

   // item execution, scan and alarm update
   always_comb begin
      cmd_in         = cmd_ff;
      ch_in          = ch_ff;
      val_in         = val_ff;
      time_in        = time_ff;
      armed_in       = armed_ff;
      next_in        = next_ff;
      alarm_time_in  = alarm_time_ff;
      alarm_valid_in = alarm_valid_ff;
      fired_in       = fired_ff;
      fch_in         = fch_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_dl_in     = best_dl_ff;

      if (ctrl.load) begin
         cmd_in   = req_command;
         ch_in    = req_channel;
         val_in   = req_value;
         fired_in = 1'b0;
         fch_in   = '0;
      end

      if (ctrl.exec) begin
         idx_in   = '0;
         found_in = 1'b0;
         best_in  = '0;
         if (is_tick) begin
            time_in = time_inc;
            // expiry of the chosen channel
            if (hit && armed_ff[next_ff]) begin
               armed_in[next_ff] = 1'b0;
               fired_in          = 1'b1;
               fch_in            = mct_pkg::CH_W'(next_ff);
            end
         end else if (in_range) begin
            armed_in[ch_idx] = (cmd_ff != mct_pkg::CMD_DISARM);
         end
      end

      // one channel per cycle, strict less keeps lowest index on ties
      if (ctrl.scan) begin
         if (armed_ff[idx_ff] && (!found_ff || (scan_dl < best_dl_ff))) begin
            best_in    = idx_ff;
            best_dl_in = scan_dl;
            found_in   = 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end

      if (ctrl.finish) begin
         alarm_valid_in = found_ff;
         if (found_ff) begin
            next_in       = best_ff;
            alarm_time_in = due ? time_inc : best_dl_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff        <= '0;
         armed_ff       <= '0;
         next_ff        <= '0;
         alarm_time_ff  <= '0;
         alarm_valid_ff <= 1'b0;
         fired_ff       <= 1'b0;
         fch_ff         <= '0;
      end else begin
         time_ff        <= time_in;
         armed_ff       <= armed_in;
         next_ff        <= next_in;
         alarm_time_ff  <= alarm_time_in;
         alarm_valid_ff <= alarm_valid_in;
         fired_ff       <= fired_in;
         fch_ff         <= fch_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ch_ff      <= ch_in;
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      best_dl_ff <= best_dl_in;
      if (dl_write) begin
         deadline_ff[ch_idx] <= dl_value;
      end
   end

   // status to controller
   always_comb begin
      stat.resched   = hit || (!is_tick && in_range);
      stat.scan_last = (idx_ff == IW'(N - 1));
   end

   assign rsp_fired         = fired_ff;
   assign rsp_fired_channel = fch_ff;
   assign rsp_current_time  = time_ff;
   assign rsp_pending       = |armed_ff;

endmodule

// ----- design/multiplexed_compare_timer_top.sv -----
// multiplexed compare timer: four compare channels sharing one alarm
//
// input channel: start with req_command, req_channel, req_value; an item is
// taken at a clock edge with start high and busy low. commands are tick,
// arm relative, arm absolute and disarm.
// result channel: rsp_valid is high for one cycle per item with rsp_fired,
// rsp_fired_channel, rsp_current_time and rsp_pending; the receiver cannot
// stall, so it must sample every strobe.
// sequence: a tick that does not fire (or an ignored channel) goes from the
// execute state straight back to idle; when the alarm is rescheduled, the
// execute state is followed by a scan that reads one deadline per cycle
// through a single read port, and a final state. busy drops with the strobe.
// configuration: apb port, min_offset at byte address 0; pready is always
// high; write only while busy is low and no result is due.
// reset (synchronous, active high): time 0, all channels disarmed, no alarm,
// min_offset 1000.
module multiplexed_compare_timer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mct_pkg::CMD_W-1:0]           req_command,
   input  logic [mct_pkg::CH_W-1:0]            req_channel,
   input  logic [mct_pkg::TIME_W-1:0]          req_value,
   output logic                                rsp_valid,
   output logic                                rsp_fired,
   output logic [mct_pkg::CH_W-1:0]            rsp_fired_channel,
   output logic [mct_pkg::TIME_W-1:0]          rsp_current_time,
   output logic                                rsp_pending,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mct_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mct_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mct_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   mct_pkg::ctrl_type          ctrl;
   mct_pkg::stat_type          stat;
   logic [mct_pkg::OFFS_W-1:0] min_offset;

   // configuration registers
   mct_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .min_offset (min_offset)
   );

   // sequencer
   mct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // timer state and scan
   mct_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_value         (req_value),
      .min_offset        (min_offset),
      .rsp_fired         (rsp_fired),
      .rsp_fired_channel (rsp_fired_channel),
      .rsp_current_time  (rsp_current_time),
      .rsp_pending       (rsp_pending)
   );

endmodule

// ----- design/mct_checker.sv -----
module mct_props (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic                           rsp_fired,
   input logic [mct_pkg::CH_W-1:0]       rsp_fired_channel,
   input logic [mct_pkg::TIME_W-1:0]     rsp_current_time
);

   // an accepted item holds the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting an item");

   // results are never back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a result only appears once work is done
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // no expiry reports a zero channel
   a_no_fire_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fired) |-> (rsp_fired_channel == '0))
      else $error("channel reported without expiry");

   // time holds while the block is idle and no result is shown
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      (!busy && !rsp_valid) |-> $stable(rsp_current_time))
      else $error("time changed while idle");

endmodule

bind multiplexed_compare_timer_top mct_props u_mct_props (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_fired         (rsp_fired),
   .rsp_fired_channel (rsp_fired_channel),
   .rsp_current_time  (rsp_current_time)
);
